/* design/joystick_to_four_wheel_drive_macros.svh */
// Assertion macros for the joystick to four-wheel drive block.
`ifndef JOYSTICK_TO_FOUR_WHEEL_DRIVE_MACROS_SVH
`define JOYSTICK_TO_FOUR_WHEEL_DRIVE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define JTFWD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jtfwd same-cycle check failed");
// next-cycle implication
`define JTFWD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jtfwd next-cycle check failed");
`else
`define JTFWD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define JTFWD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/jtfwd_pkg.sv */
// Package: types, patterns, register indexes and thresholds for the drive controller.
package jtfwd_pkg;

    localparam int STICK_FRAC_BITS = 14;

    localparam int STICK_W = 16;
    localparam int CFG_W   = 15;
    localparam int DUTY_W  = 8;
    localparam int CFG_IDX_W = 3;

    // direction thresholds, widened so any fraction width compares exactly
    localparam logic signed [17:0] HALF_TH  = 18'(1 << (STICK_FRAC_BITS - 1));
    localparam logic signed [17:0] EIGHT_TH = 18'((4 << STICK_FRAC_BITS) / 5);

    localparam logic [7:0] PAT_UP         = 8'hA5;
    localparam logic [7:0] PAT_UP_RIGHT   = 8'h21;
    localparam logic [7:0] PAT_UP_LEFT    = 8'h84;
    localparam logic [7:0] PAT_DOWN       = 8'h5A;
    localparam logic [7:0] PAT_DOWN_LEFT  = 8'h48;
    localparam logic [7:0] PAT_DOWN_RIGHT = 8'h12;
    localparam logic [7:0] PAT_LEFT       = 8'h96;
    localparam logic [7:0] PAT_RIGHT      = 8'h69;
    localparam logic [7:0] PAT_CW         = 8'h55;
    localparam logic [7:0] PAT_CCW        = 8'hAA;

    localparam logic [1:0] LIFT_STOP  = 2'd0;
    localparam logic [1:0] LIFT_UP    = 2'd1;
    localparam logic [1:0] LIFT_LOWER = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_STICK_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LOW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_HIGH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFT_DEADZONE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_DEADZONE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_GATING = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DRIVE,
        S_DRIVE_DIV,
        S_TURN,
        S_TURN_DIV,
        S_DONE
    } t_state;

endpackage

/* design/joystick_to_four_wheel_drive.sv */
// Top level: joystick sample to H-bridge pattern, PWM duty and lift command.

// The result of an item is registered as the sequencer leaves its last step,
// and the block turns ready at that same edge. After acceptance the sequencer
// steps through drive, turn and done, with a division after drive or turn for
// each duty scaling that falls in the linear range. Both scalings share one
// multiplier and one restoring divider that yields one quotient bit per cycle
// (8 bits). A new item is accepted once the sequencer is idle, even while the
// previous result still waits on the output register; a result that finds the
// output register still full holds the sequencer in its last step. Lift and
// turn deadzones, the stick range and the duty clamps are written through the
// configuration port only while no item is in flight: a user rule, not enforced.

`include "joystick_to_four_wheel_drive_macros.svh"

module joystick_to_four_wheel_drive (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [jtfwd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [jtfwd_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [jtfwd_pkg::STICK_W-1:0]   i_lift_stick,
    input  logic signed [jtfwd_pkg::STICK_W-1:0]   i_turn_stick,
    input  logic signed [jtfwd_pkg::STICK_W-1:0]   i_drive_x,
    input  logic signed [jtfwd_pkg::STICK_W-1:0]   i_drive_y,
    input  logic                                   i_clear_left,
    input  logic                                   i_clear_right,
    input  logic                                   i_clear_front,
    input  logic                                   i_clear_back,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [7:0]                             o_bridge_pins,
    output logic [jtfwd_pkg::DUTY_W-1:0]           o_duty,
    output logic [1:0]                             o_lift_command
);
    import jtfwd_pkg::*;

    // configuration
    logic [CFG_W-1:0]  r_stick_low, r_stick_high, r_lift_dz, r_turn_dz;
    logic [DUTY_W-1:0] r_duty_low, r_duty_high;
    logic              r_gate;

    // control and held state
    t_state r_state, n_state;
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_held_pattern, n_held_pattern;
    logic [DUTY_W-1:0] r_held_drive_duty, n_held_drive_duty;

    // item payload and divider datapath
    logic signed [STICK_W-1:0] r_x, n_x, r_y, n_y, r_turn, n_turn;
    logic [3:0]        r_clr, n_clr;
    logic [1:0]        r_lift_cmd, n_lift_cmd;
    logic [DUTY_W-1:0] r_duty_res, n_duty_res;
    logic [22:0]       r_rem, n_rem, r_dsh, n_dsh;
    logic [7:0]        r_quo, n_quo;
    logic [2:0]        r_cnt, n_cnt;
    logic [7:0]        r_o_pins, n_o_pins;
    logic [DUTY_W-1:0] r_o_duty, n_o_duty;
    logic [1:0]        r_o_lift, n_o_lift;

    logic in_acc;
    logic in_div;
    logic signed [16:0] lift_ext, dz_ext;
    logic [STICK_W-1:0] ax, ay, turn_mag;
    logic signed [17:0] xs, ys;
    logic ok_l, ok_r, ok_f, ok_b;
    logic drv_take;
    logic [7:0] drv_pat;
    logic turn_on;

    // shared scaling front end
    logic [STICK_W-1:0] sc_m;
    logic signed [15:0] sc_den;
    logic signed [16:0] sc_den_ext, sc_d;
    logic signed [8:0]  sc_w;
    logic               sc_fast;
    logic [DUTY_W-1:0]  sc_fast_val;
    logic [22:0]        sc_prod;

    // divider step
    logic        dv_ge;
    logic [7:0]  dv_quo;
    logic [8:0]  dv_sum;

    assign in_acc = i_in_valid && o_in_ready;
    assign in_div = (r_state == S_DRIVE_DIV) || (r_state == S_TURN_DIV);
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_bridge_pins = r_o_pins;
    assign o_duty = r_o_duty;
    assign o_lift_command = r_o_lift;

    assign lift_ext = {i_lift_stick[STICK_W-1], i_lift_stick};
    assign dz_ext   = {2'b00, r_lift_dz};

    assign ax       = r_x[STICK_W-1] ? 16'(-r_x) : r_x;
    assign ay       = r_y[STICK_W-1] ? 16'(-r_y) : r_y;
    assign turn_mag = r_turn[STICK_W-1] ? 16'(-r_turn) : r_turn;
    assign xs = {{2{r_x[STICK_W-1]}}, r_x};
    assign ys = {{2{r_y[STICK_W-1]}}, r_y};
    assign ok_l = !r_gate || r_clr[3];
    assign ok_r = !r_gate || r_clr[2];
    assign ok_f = !r_gate || r_clr[1];
    assign ok_b = !r_gate || r_clr[0];
    assign turn_on = (turn_mag >= {1'b0, r_turn_dz});

    always_comb begin
        drv_take = 1'b0;
        drv_pat  = PAT_LEFT;
        if (ax >= ay) begin
            if (xs < 0 && ok_l) begin
                drv_take = 1'b1;
                drv_pat  = PAT_LEFT;
                if (xs < -HALF_TH && ys > EIGHT_TH) begin
                    drv_pat = PAT_UP_LEFT;
                end else if (xs < -HALF_TH && ys < -EIGHT_TH) begin
                    drv_pat = PAT_DOWN_LEFT;
                end
            end else if (xs > 0 && ok_r) begin
                drv_take = 1'b1;
                drv_pat  = PAT_RIGHT;
                if (xs > HALF_TH && ys > EIGHT_TH) begin
                    drv_pat = PAT_UP_RIGHT;
                end else if (xs > HALF_TH && ys < -EIGHT_TH) begin
                    drv_pat = PAT_DOWN_RIGHT;
                end
            end
        end else begin
            if (ys > 0 && ok_f) begin
                drv_take = 1'b1;
                drv_pat  = PAT_UP;
                if (xs > EIGHT_TH && ys > HALF_TH) begin
                    drv_pat = PAT_UP_RIGHT;
                end else if (xs < -EIGHT_TH && ys > HALF_TH) begin
                    drv_pat = PAT_UP_LEFT;
                end
            end else if (ys < 0 && ok_b) begin
                drv_take = 1'b1;
                drv_pat  = PAT_DOWN;
                if (xs > EIGHT_TH && ys < -HALF_TH) begin
                    drv_pat = PAT_DOWN_RIGHT;
                end else if (xs < -EIGHT_TH && ys < -HALF_TH) begin
                    drv_pat = PAT_DOWN_LEFT;
                end
            end
        end
    end

    // duty scaling: clamped cases resolve at once, the linear range divides
    assign sc_m       = (r_state == S_DRIVE) ? ((ax >= ay) ? ax : ay) : turn_mag;
    assign sc_den     = $signed({1'b0, r_stick_high}) - $signed({1'b0, r_stick_low});
    assign sc_den_ext = {sc_den[15], sc_den};
    assign sc_d       = $signed({1'b0, sc_m}) - $signed({2'b00, r_stick_low});
    assign sc_w       = $signed({1'b0, r_duty_high}) - $signed({1'b0, r_duty_low});
    assign sc_prod    = {8'b0, sc_d[14:0]} * {15'b0, sc_w[7:0]};

    always_comb begin
        sc_fast     = 1'b1;
        sc_fast_val = r_duty_low;
        if (sc_den[15] || sc_den == 16'sd0) begin
            sc_fast_val = (sc_d > 0) ? r_duty_high : r_duty_low;
        end else if (sc_w[8]) begin
            sc_fast_val = (sc_d < sc_den_ext) ? r_duty_high : r_duty_low;
        end else if (sc_d[16]) begin
            sc_fast_val = r_duty_low;
        end else if (sc_d > sc_den_ext) begin
            sc_fast_val = r_duty_high;
        end else begin
            sc_fast = 1'b0;
        end
    end

    assign dv_ge  = (r_rem >= r_dsh);
    assign dv_quo = {r_quo[6:0], dv_ge};
    assign dv_sum = {1'b0, r_duty_low} + {1'b0, dv_quo};

    always_comb begin
        n_state           = r_state;
        n_out_valid       = r_out_valid;
        n_held_pattern    = r_held_pattern;
        n_held_drive_duty = r_held_drive_duty;
        n_x        = r_x;
        n_y        = r_y;
        n_turn     = r_turn;
        n_clr      = r_clr;
        n_lift_cmd = r_lift_cmd;
        n_duty_res = r_duty_res;
        n_rem      = r_rem;
        n_dsh      = r_dsh;
        n_quo      = r_quo;
        n_cnt      = r_cnt;
        n_o_pins   = r_o_pins;
        n_o_duty   = r_o_duty;
        n_o_lift   = r_o_lift;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_x    = i_drive_x;
                    n_y    = i_drive_y;
                    n_turn = i_turn_stick;
                    n_clr  = {i_clear_left, i_clear_right, i_clear_front, i_clear_back};
                    if (lift_ext > dz_ext) begin
                        n_lift_cmd = LIFT_UP;
                    end else if (lift_ext < -dz_ext) begin
                        n_lift_cmd = LIFT_LOWER;
                    end else begin
                        n_lift_cmd = LIFT_STOP;
                    end
                    n_state = S_DRIVE;
                end
            end
            S_DRIVE: begin
                n_state = S_TURN;
                if (drv_take) begin
                    n_held_pattern = drv_pat;
                    if (sc_fast) begin
                        n_held_drive_duty = sc_fast_val;
                    end else begin
                        n_rem   = sc_prod;
                        n_dsh   = {1'b0, sc_den[14:0], 7'b0};
                        n_quo   = 8'd0;
                        n_cnt   = 3'd0;
                        n_state = S_DRIVE_DIV;
                    end
                end
            end
            S_DRIVE_DIV: begin
                n_rem = dv_ge ? (r_rem - r_dsh) : r_rem;
                n_dsh = r_dsh >> 1;
                n_quo = dv_quo;
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    n_held_drive_duty = dv_sum[7:0];
                    n_state = S_TURN;
                end
            end
            S_TURN: begin
                n_state = S_DONE;
                if (turn_on) begin
                    n_held_pattern = r_turn[STICK_W-1] ? PAT_CW : PAT_CCW;
                    if (sc_fast) begin
                        n_duty_res = sc_fast_val;
                    end else begin
                        n_rem   = sc_prod;
                        n_dsh   = {1'b0, sc_den[14:0], 7'b0};
                        n_quo   = 8'd0;
                        n_cnt   = 3'd0;
                        n_state = S_TURN_DIV;
                    end
                end else begin
                    n_duty_res = r_held_drive_duty;
                end
            end
            S_TURN_DIV: begin
                n_rem = dv_ge ? (r_rem - r_dsh) : r_rem;
                n_dsh = r_dsh >> 1;
                n_quo = dv_quo;
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    n_duty_res = dv_sum[7:0];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_o_pins    = r_held_pattern;
                    n_o_duty    = r_duty_res;
                    n_o_lift    = r_lift_cmd;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_out_valid       <= 1'b0;
            r_held_pattern    <= 8'd0;
            r_held_drive_duty <= '0;
            r_stick_low       <= 15'd0;
            r_stick_high      <= 15'd16384;
            r_duty_low        <= 8'd0;
            r_duty_high       <= 8'd255;
            r_lift_dz         <= 15'd1638;
            r_turn_dz         <= 15'd1638;
            r_gate            <= 1'b0;
        end else begin
            r_state           <= n_state;
            r_out_valid       <= n_out_valid;
            r_held_pattern    <= n_held_pattern;
            r_held_drive_duty <= n_held_drive_duty;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_STICK_LOW:     r_stick_low  <= i_cfg_data;
                    CFG_STICK_HIGH:    r_stick_high <= i_cfg_data;
                    CFG_DUTY_LOW:      r_duty_low   <= i_cfg_data[DUTY_W-1:0];
                    CFG_DUTY_HIGH:     r_duty_high  <= i_cfg_data[DUTY_W-1:0];
                    CFG_LIFT_DEADZONE: r_lift_dz    <= i_cfg_data;
                    CFG_TURN_DEADZONE: r_turn_dz    <= i_cfg_data;
                    CFG_SENSOR_GATING: r_gate       <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_y        <= n_y;
        r_turn     <= n_turn;
        r_clr      <= n_clr;
        r_lift_cmd <= n_lift_cmd;
        r_duty_res <= n_duty_res;
        r_rem      <= n_rem;
        r_dsh      <= n_dsh;
        r_quo      <= n_quo;
        r_cnt      <= n_cnt;
        r_o_pins   <= n_o_pins;
        r_o_duty   <= n_o_duty;
        r_o_lift   <= n_o_lift;
    end

    `JTFWD_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, in_acc, r_state == S_DRIVE)
    `JTFWD_ASSERT_SAME(a_div_bound, i_clk, i_rst_n, in_div, r_rem < {r_dsh[21:0], 1'b0})
    `JTFWD_ASSERT_NEXT(a_done_loads, i_clk, i_rst_n, r_state == S_DONE && !r_out_valid,
        r_out_valid && r_state == S_IDLE)

endmodule
